// ----- src/lrt_pkg.sv -----
// lrt_pkg: shared types, codes and helpers of the route table
// no dependencies; used by every module of the block
`default_nettype none
package lrt_pkg;

   localparam int ROUTE_ENTRIES_DEF = 16;
   localparam int NEXTHOP_BITS_DEF  = 8;
   localparam logic [7:0] FULL_LEN  = 8'd128;

   localparam logic [2:0] FN_LOOKUP = 3'd0;
   localparam logic [2:0] FN_ADD    = 3'd1;
   localparam logic [2:0] FN_RM_SLOT = 3'd2;
   localparam logic [2:0] FN_RM_HOP = 3'd3;
   localparam logic [2:0] FN_QUERY  = 3'd4;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_MISS    = 2'd1;
   localparam logic [1:0] STAT_FULL    = 2'd2;
   localparam logic [1:0] STAT_UNKNOWN = 2'd3;

   typedef struct packed {
      logic [2:0]  func;
      logic [63:0] addr_hi;
      logic [63:0] addr_lo;
      logic [7:0]  prefix_len;
      logic [7:0]  nexthop_id;
      logic        nexthop_known;
      logic [3:0]  entry_slot;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [3:0] slot;
      logic [7:0] route_nexthop;
      logic [7:0] route_len;
      logic [4:0] route_count;
      logic       nexthop_in_use;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic scan;
      logic apply;
      logic insert;
      logic load;
   } lrt_cmd_type;

   typedef struct packed {
      logic need_insert;
   } lrt_stat_type;

   // top len bits set
   function automatic logic [127:0] prefix_mask(input logic [7:0] len);
      logic [127:0] m;
      m = ~({128{1'b1}} >> len);
      return m;
   endfunction

endpackage
`default_nettype wire

// ----- src/lpm_route_table_lru_top.sv -----
// channel  | ports                          | handshake
// request  | req_valid, req_ready, req_data | valid/ready, item taken when both high
// response | rsp_valid, rsp_ready, rsp_data | valid/ready, held until taken
// config   | csr_wr_en, csr_wr_data         | write on enable, no wait
//
// one item at a time; from accept to result: scan of the route memory, drain, apply,
// an insert for an add that goes past its lookup; the scan reads one entry per cycle
// reset is synchronous; the table comes up empty with eviction enabled
// a finished result waits in the output register; the next item may be accepted then
// lrt_pkg, lrt_ctrl, lrt_datapath
`default_nettype none
module lpm_route_table_lru_top #(
   parameter int ROUTE_ENTRIES = lrt_pkg::ROUTE_ENTRIES_DEF,
   parameter int NEXTHOP_BITS  = lrt_pkg::NEXTHOP_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire lrt_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output lrt_pkg::rsp_type      rsp_data,
   input  wire logic             csr_wr_en,
   input  wire logic             csr_wr_data
);
   localparam int SW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;

   lrt_pkg::lrt_cmd_type  cmd;
   lrt_pkg::lrt_stat_type stat;
   logic [SW-1:0]         scan_idx;

   lrt_ctrl #(
      .ROUTE_ENTRIES(ROUTE_ENTRIES)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .stat     (stat),
      .cmd      (cmd),
      .scan_idx (scan_idx)
   );

   lrt_datapath #(
      .ROUTE_ENTRIES(ROUTE_ENTRIES),
      .NEXTHOP_BITS (NEXTHOP_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .scan_idx   (scan_idx),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .stat       (stat),
      .rsp_data   (rsp_data)
   );

`ifndef SYNTHESIS
   // an accepted item closes the request side until its result is out
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while busy");

   // failed operations report no route
   a_fail_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != lrt_pkg::STAT_OK)
      |-> (rsp_data.slot == 4'd0 && rsp_data.route_len == 8'd0
           && rsp_data.route_nexthop == 8'd0))
      else $error("failed item carries route fields");

   // in-use flag only on a successful query
   a_inuse_only_query: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.nexthop_in_use) |-> (rsp_data.status == lrt_pkg::STAT_OK))
      else $error("in-use flag on failed item");
`endif

endmodule
`default_nettype wire

// ----- src/lrt_ctrl.sv -----
// lrt_ctrl: sequencer of the route table, drives the slot scan and result handoff
// depends on lrt_pkg
`default_nettype none
module lrt_ctrl #(
   parameter int ROUTE_ENTRIES = lrt_pkg::ROUTE_ENTRIES_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   input  wire lrt_pkg::lrt_stat_type stat,
   output lrt_pkg::lrt_cmd_type     cmd,
   output logic [((ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1)-1:0] scan_idx
);
   localparam int SW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_DRAIN  = 3'd2;
   localparam logic [2:0] S_APPLY  = 3'd3;
   localparam logic [2:0] S_INSERT = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [SW-1:0] idx_ff, idx_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               idx_in    = '0;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (idx_ff == SW'(ROUTE_ENTRIES - 1)) begin
               state_in = S_DRAIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            // last read entry is evaluated here
            state_in = S_APPLY;
         end
         S_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = stat.need_insert ? S_INSERT : S_DONE;
         end
         S_INSERT: begin
            cmd.insert = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign scan_idx  = idx_ff;

endmodule
`default_nettype wire

// ----- src/lrt_datapath.sv -----
// lrt_datapath: route storage, recency ranks, scan compare and result register
// depends on lrt_pkg
`default_nettype none
module lrt_datapath #(
   parameter int ROUTE_ENTRIES = lrt_pkg::ROUTE_ENTRIES_DEF,
   parameter int NEXTHOP_BITS  = lrt_pkg::NEXTHOP_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lrt_pkg::req_type     req_data,
   input  wire lrt_pkg::lrt_cmd_type cmd,
   input  wire logic [((ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1)-1:0] scan_idx,
   input  wire logic                 csr_wr_en,
   input  wire logic                 csr_wr_data,
   output lrt_pkg::lrt_stat_type     stat,
   output lrt_pkg::rsp_type          rsp_data
);
   localparam int SW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
   localparam int CW = $clog2(ROUTE_ENTRIES + 1);
   localparam int KW = 1 + 8 + SW;
   localparam int EW = 128 + 8 + NEXTHOP_BITS;

   logic [EW-1:0]           mem [ROUTE_ENTRIES];
   logic [EW-1:0]           rd_ff;
   lrt_pkg::req_type        req_ff;
   logic                    evict_en_ff;
   logic                    eval_ff;
   logic [SW-1:0]           eval_idx_ff;
   logic                    valid_ff [ROUTE_ENTRIES];
   logic [SW-1:0]           rank_ff [ROUTE_ENTRIES];
   logic [CW-1:0]           total_ff;
   logic                    found_ff;
   logic [SW-1:0]           best_slot_ff;
   logic [KW-1:0]           best_key_ff;
   logic [7:0]              best_len_ff;
   logic [NEXTHOP_BITS-1:0] best_hop_ff;
   logic [7:0]              es_len_ff;
   logic [NEXTHOP_BITS-1:0] es_hop_ff;
   logic                    removed_ff;
   logic                    inuse_ff;
   lrt_pkg::rsp_type        res_ff;
   lrt_pkg::rsp_type        rsp_data_ff;

   logic [63:0]             rd_hi, rd_lo;
   logic [7:0]              rd_len;
   logic [NEXTHOP_BITS-1:0] rd_hop, hop_in;
   logic [7:0]              len_clamp;
   logic                    known, hit, full_len, cand_ok, hop_eq;
   logic [SW-1:0]           cand_rank, lru_slot, free_slot, ins_slot, es_slot, rm_idx;
   logic [KW-1:0]           cand_key;
   logic                    table_full, ins_ok, es_ok, rm_en, front_en, hop_same;
   logic [SW-1:0]           rm_rank, front_rank;

   assign rd_hi  = rd_ff[EW-1 -: 64];
   assign rd_lo  = rd_ff[EW-65 -: 64];
   assign rd_len = rd_ff[NEXTHOP_BITS+7 -: 8];
   assign rd_hop = rd_ff[NEXTHOP_BITS-1:0];

   assign hop_in    = NEXTHOP_BITS'(req_ff.nexthop_id);
   assign len_clamp = (req_ff.prefix_len > lrt_pkg::FULL_LEN) ? lrt_pkg::FULL_LEN
                                                              : req_ff.prefix_len;
   assign known     = req_ff.nexthop_known;

   assign hit = ((({req_ff.addr_hi, req_ff.addr_lo} ^ {rd_hi, rd_lo})
                 & lrt_pkg::prefix_mask(rd_len)) == 128'd0);
   assign cand_rank = rank_ff[eval_idx_ff];
   assign full_len  = (rd_len == lrt_pkg::FULL_LEN);
   // full-length hits: most recent wins; others: longest, then least recent
   assign cand_key  = {full_len, rd_len, full_len ? ~cand_rank : cand_rank};
   assign cand_ok   = valid_ff[eval_idx_ff] && hit && (!found_ff || cand_key > best_key_ff);
   assign hop_eq    = valid_ff[eval_idx_ff] && (rd_hop == hop_in);

   always_comb begin
      lru_slot  = '0;
      free_slot = '0;
      for (int i = 0; i < ROUTE_ENTRIES; i++) begin
         if (valid_ff[i] && rank_ff[i] == SW'(total_ff - 1'b1)) begin
            lru_slot = SW'(i);
         end
      end
      for (int i = ROUTE_ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_slot = SW'(i);
         end
      end
   end

   assign table_full = (total_ff == CW'(ROUTE_ENTRIES));
   assign ins_slot   = table_full ? lru_slot : free_slot;
   assign ins_ok     = !table_full || evict_en_ff;
   assign es_slot    = SW'(req_ff.entry_slot);
   assign es_ok      = (32'(req_ff.entry_slot) < 32'(ROUTE_ENTRIES)) && valid_ff[es_slot];
   assign hop_same   = (best_hop_ff == hop_in);

   assign stat.need_insert = (req_ff.func == lrt_pkg::FN_ADD) && known
                             && !(found_ff && hop_same);

   always_comb begin
      rm_en  = 1'b0;
      rm_idx = eval_idx_ff;
      if (eval_ff && hop_eq && known && req_ff.func == lrt_pkg::FN_RM_HOP) begin
         rm_en = 1'b1;
      end else if (cmd.apply && req_ff.func == lrt_pkg::FN_ADD && known && found_ff
                   && !hop_same) begin
         rm_en  = 1'b1;
         rm_idx = best_slot_ff;
      end else if (cmd.apply && req_ff.func == lrt_pkg::FN_RM_SLOT && es_ok) begin
         rm_en  = 1'b1;
         rm_idx = es_slot;
      end
   end

   assign front_en = cmd.apply && found_ff
                     && (req_ff.func == lrt_pkg::FN_LOOKUP
                         || (req_ff.func == lrt_pkg::FN_ADD && known && hop_same));
   assign rm_rank    = rank_ff[rm_idx];
   assign front_rank = rank_ff[best_slot_ff];

   // route storage, one read port on the scan index
   always_ff @(posedge clock) begin
      if (cmd.insert && ins_ok) begin
         mem[ins_slot] <= {req_ff.addr_hi, req_ff.addr_lo, len_clamp, hop_in};
      end
      rd_ff <= mem[scan_idx];
   end

   // ranks, valid bits and count
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < ROUTE_ENTRIES; j++) begin
            valid_ff[j] <= 1'b0;
            rank_ff[j]  <= '0;
         end
         total_ff <= '0;
      end else if (rm_en) begin
         valid_ff[rm_idx] <= 1'b0;
         for (int j = 0; j < ROUTE_ENTRIES; j++) begin
            if (valid_ff[j] && rank_ff[j] > rm_rank) begin
               rank_ff[j] <= rank_ff[j] - 1'b1;
            end
         end
         total_ff <= total_ff - 1'b1;
      end else if (front_en) begin
         for (int j = 0; j < ROUTE_ENTRIES; j++) begin
            if (SW'(j) != best_slot_ff && valid_ff[j] && rank_ff[j] < front_rank) begin
               rank_ff[j] <= rank_ff[j] + 1'b1;
            end
         end
         rank_ff[best_slot_ff] <= '0;
      end else if (cmd.insert && ins_ok) begin
         // the evicted entry is overwritten in place
         for (int j = 0; j < ROUTE_ENTRIES; j++) begin
            if (valid_ff[j] && SW'(j) != ins_slot) begin
               rank_ff[j] <= rank_ff[j] + 1'b1;
            end
         end
         rank_ff[ins_slot]  <= '0;
         valid_ff[ins_slot] <= 1'b1;
         if (!table_full) begin
            total_ff <= total_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         evict_en_ff <= 1'b1;
         eval_ff     <= 1'b0;
         found_ff    <= 1'b0;
         removed_ff  <= 1'b0;
         inuse_ff    <= 1'b0;
      end else begin
         eval_ff     <= cmd.scan;
         eval_idx_ff <= scan_idx;
         if (csr_wr_en) begin
            evict_en_ff <= csr_wr_data;
         end
         if (cmd.start) begin
            req_ff     <= req_data;
            found_ff   <= 1'b0;
            removed_ff <= 1'b0;
            inuse_ff   <= 1'b0;
            res_ff     <= '{status: lrt_pkg::STAT_MISS, default: '0};
         end
         if (eval_ff) begin
            if (cand_ok) begin
               found_ff     <= 1'b1;
               best_slot_ff <= eval_idx_ff;
               best_key_ff  <= cand_key;
               best_len_ff  <= rd_len;
               best_hop_ff  <= rd_hop;
            end
            if (eval_idx_ff == es_slot) begin
               es_len_ff <= rd_len;
               es_hop_ff <= rd_hop;
            end
            if (hop_eq) begin
               inuse_ff <= 1'b1;
               if (known && req_ff.func == lrt_pkg::FN_RM_HOP) begin
                  removed_ff <= 1'b1;
               end
            end
         end
         if (cmd.apply) begin
            case (req_ff.func)
               lrt_pkg::FN_LOOKUP: begin
                  if (found_ff) begin
                     res_ff.status        <= lrt_pkg::STAT_OK;
                     res_ff.slot          <= 4'(best_slot_ff);
                     res_ff.route_nexthop <= 8'(best_hop_ff);
                     res_ff.route_len     <= best_len_ff;
                  end
               end
               lrt_pkg::FN_ADD: begin
                  if (!known) begin
                     res_ff.status <= lrt_pkg::STAT_UNKNOWN;
                  end else if (found_ff && hop_same) begin
                     res_ff.status        <= lrt_pkg::STAT_OK;
                     res_ff.slot          <= 4'(best_slot_ff);
                     res_ff.route_nexthop <= 8'(best_hop_ff);
                     res_ff.route_len     <= best_len_ff;
                  end
               end
               lrt_pkg::FN_RM_SLOT: begin
                  if (es_ok) begin
                     res_ff.status        <= lrt_pkg::STAT_OK;
                     res_ff.slot          <= req_ff.entry_slot;
                     res_ff.route_nexthop <= 8'(es_hop_ff);
                     res_ff.route_len     <= es_len_ff;
                  end
               end
               lrt_pkg::FN_RM_HOP: begin
                  res_ff.status <= (known && removed_ff) ? lrt_pkg::STAT_OK
                                                         : lrt_pkg::STAT_MISS;
               end
               lrt_pkg::FN_QUERY: begin
                  if (!known) begin
                     res_ff.status <= lrt_pkg::STAT_UNKNOWN;
                  end else begin
                     res_ff.status         <= lrt_pkg::STAT_OK;
                     res_ff.nexthop_in_use <= inuse_ff;
                  end
               end
               default: begin
               end
            endcase
         end
         if (cmd.insert) begin
            if (ins_ok) begin
               res_ff.status        <= lrt_pkg::STAT_OK;
               res_ff.slot          <= 4'(ins_slot);
               res_ff.route_nexthop <= 8'(hop_in);
               res_ff.route_len     <= len_clamp;
            end else begin
               res_ff.status <= lrt_pkg::STAT_FULL;
            end
         end
         if (cmd.load) begin
            rsp_data_ff <= {res_ff.status, res_ff.slot, res_ff.route_nexthop,
                            res_ff.route_len, 5'(total_ff), res_ff.nexthop_in_use};
         end
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule
`default_nettype wire
